// File: rtl/lrc_pkg.sv
// shared types and constants of the loop revolution counter
package lrc_pkg;

    localparam int unsigned ANGLE_W = 16;
    localparam int unsigned COUNT_W = 16;

    // half-turn window for the first section: |angle - 32768| <= 5461
    localparam logic [ANGLE_W-1:0] SECTION_LO = 16'd27307;
    localparam logic [ANGLE_W-1:0] SECTION_HI = 16'd38229;
    localparam logic [ANGLE_W-1:0] HALF_TURN  = 16'd32768;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [ANGLE_W-1:0] bin_angle;
        logic               in_crosswind;
        logic               trans_in;
    } t_lrc_in;

    typedef struct packed {
        logic [COUNT_W-1:0] current_revs;
        logic [COUNT_W-1:0] total_revs;
        logic               section_done;
    } t_lrc_out;

    typedef struct packed {
        logic [ANGLE_W-1:0] prior_angle;
        logic               angle_seeded;
        logic               section_flag;
        logic [COUNT_W-1:0] current_count;
        logic [COUNT_W-1:0] total_count;
    } t_lrc_state;

endpackage

// File: rtl/lrc_update.sv
// next-state logic for one telemetry sample
module lrc_update (
    input  lrc_pkg::t_lrc_in    i_item,
    input  lrc_pkg::t_lrc_state i_state,
    output lrc_pkg::t_lrc_state o_state
);

    logic [lrc_pkg::ANGLE_W:0]   diff;
    logic                        in_window;
    logic                        is_wrap;
    logic                        is_fwd;
    logic                        flag_now;
    logic [lrc_pkg::COUNT_W-1:0] cur_inc;
    logic [lrc_pkg::COUNT_W-1:0] tot_inc;

    // signed difference, one bit wider than the angle
    assign diff = {1'b0, i_item.bin_angle} - {1'b0, i_state.prior_angle};
    assign in_window = (i_item.bin_angle >= lrc_pkg::SECTION_LO)
                    && (i_item.bin_angle <= lrc_pkg::SECTION_HI);
    // more than a half turn up
    assign is_wrap = !diff[lrc_pkg::ANGLE_W]
                  && (diff[lrc_pkg::ANGLE_W-1:0] > lrc_pkg::HALF_TURN);
    // strictly between minus a half turn and zero
    assign is_fwd = diff[lrc_pkg::ANGLE_W] && diff[lrc_pkg::ANGLE_W-1]
                 && (diff[lrc_pkg::ANGLE_W-2:0] != '0);
    assign flag_now = i_state.section_flag || in_window;

    assign cur_inc = (i_state.current_count == lrc_pkg::COUNT_MAX)
                   ? i_state.current_count : i_state.current_count + 1'b1;
    assign tot_inc = (i_state.total_count == lrc_pkg::COUNT_MAX)
                   ? i_state.total_count : i_state.total_count + 1'b1;

    always_comb begin
        o_state = i_state;
        if (i_item.in_crosswind) begin
            if (!i_state.angle_seeded) begin
                o_state.prior_angle  = i_item.bin_angle;
                o_state.angle_seeded = 1'b1;
            end else begin
                o_state.section_flag = flag_now;
                if (is_wrap) begin
                    o_state.prior_angle = i_item.bin_angle;
                    if (flag_now) begin
                        o_state.current_count = cur_inc;
                        o_state.total_count   = tot_inc;
                    end
                end else if (is_fwd) begin
                    o_state.prior_angle = i_item.bin_angle;
                end
            end
        end else if (i_item.trans_in) begin
            o_state.angle_seeded  = 1'b0;
            o_state.section_flag  = 1'b0;
            o_state.current_count = '0;
        end
    end

endmodule

// File: rtl/loop_revolution_counter_core.sv
// top level of the loop revolution counter
// Counts kite loop revolutions from telemetry samples. Each request carries a
// 16-bit binary loop angle and two mode flags; each one yields exactly one
// result with the current count, the total count and the first-section flag,
// all taken after that sample's update. A request is registered on entry,
// the state update is combinational logic behind that register, and the
// result lands in an output register. One request is taken every cycle as
// long as results are taken. Both counts saturate at 65535.
module loop_revolution_counter_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lrc_pkg::t_lrc_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lrc_pkg::t_lrc_out o_out_data
);

    // input register
    logic                r_in_valid;
    lrc_pkg::t_lrc_in    r_in_data;
    // counter state
    lrc_pkg::t_lrc_state r_state;
    lrc_pkg::t_lrc_state n_state;
    // result register
    logic                r_out_valid;
    lrc_pkg::t_lrc_out   r_out_data;

    logic advance;

    // the result register frees up when empty or taken this cycle
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    lrc_update u_update (
        .i_item  (r_in_data),
        .i_state (r_state),
        .o_state (n_state)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    // state and result update, one request per cycle while the result register frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_data.current_revs <= n_state.current_count;
            r_out_data.total_revs   <= n_state.total_count;
            r_out_data.section_done <= n_state.section_flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: rtl/lrc_checker.sv
// port-level checks of the loop revolution counter
module lrc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input lrc_pkg::t_lrc_in  i_in_data,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input lrc_pkg::t_lrc_out o_out_data
);

    // reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // current count never exceeds total count
    a_cur_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.current_revs <= o_out_data.total_revs)
        else $error("current count above total count");

    // counting only happens once the first section is complete
    a_count_needs_section: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.current_revs != '0) |-> o_out_data.section_done)
        else $error("revolutions counted without first section");

endmodule

bind loop_revolution_counter_core lrc_checker u_lrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: bench/tb_loop_revolution_counter_core.sv
// self-checking testbench of the loop revolution counter core
module tb_loop_revolution_counter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_BITS = lrc_pkg::ANGLE_W;
    localparam int COUNT_BITS = lrc_pkg::COUNT_W;

    // flight mode as seen through the two flags of a request
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_CW,
        MODE_TIN,
        MODE_BOTH
    } t_flight_mode;

    // one line of the directed plan; want is only used when known is set
    typedef struct {
        lrc_pkg::t_lrc_in  req;
        bit                known;
        lrc_pkg::t_lrc_out want;
    } t_plan_row;

    localparam int HALF_TURN_UNITS = 32768;
    localparam int SECTION_UNITS   = 5461;
    localparam int RANDOM_ITEMS    = 1170;
    localparam int TAIL_ITEMS      = 60;
    localparam int HOLD_OFF_CYCLES = 50;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    lrc_pkg::t_lrc_in  i_in_data   = '0;
    logic              i_out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    lrc_pkg::t_lrc_out o_out_data;

    // predicted state of the counter and the results still owed by the block
    lrc_pkg::t_lrc_state loop_st = '0;
    lrc_pkg::t_lrc_out   counts_due[$];
    int unsigned         fail_count = 0;

    // steady: no idling on either side; hurry: requests left without gaps
    bit steady        = 1'b0;
    bit hold_off_req  = 1'b0;
    bit hold_off_done = 1'b0;
    int hurry         = 0;

    always #5 i_clk = ~i_clk;

    loop_revolution_counter_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    function automatic lrc_pkg::t_lrc_in make_req(logic [ANGLE_BITS-1:0] angle,
                                                  t_flight_mode mode);
        lrc_pkg::t_lrc_in r;
        r.bin_angle    = angle;
        r.in_crosswind = (mode == MODE_CW) || (mode == MODE_BOTH);
        r.trans_in     = (mode == MODE_TIN) || (mode == MODE_BOTH);
        return r;
    endfunction

    function automatic t_plan_row free_row(logic [ANGLE_BITS-1:0] angle, t_flight_mode mode);
        t_plan_row row;
        row.req   = make_req(angle, mode);
        row.known = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic t_plan_row known_row(logic [ANGLE_BITS-1:0] angle, t_flight_mode mode,
                                            int cur, int tot, bit sec);
        t_plan_row row;
        row.req   = make_req(angle, mode);
        row.known = 1'b1;
        row.want  = '{current_revs: COUNT_BITS'(cur), total_revs: COUNT_BITS'(tot),
                      section_done: sec};
        return row;
    endfunction

    // advance the predicted counter by one sample and return the counts after it
    function automatic lrc_pkg::t_lrc_out track_sample(lrc_pkg::t_lrc_in req);
        int                win_off;
        int                diff;
        lrc_pkg::t_lrc_out res;
        if (req.in_crosswind) begin
            if (!loop_st.angle_seeded) begin
                // first crosswind sample only seeds the stored angle
                loop_st.prior_angle  = req.bin_angle;
                loop_st.angle_seeded = 1'b1;
            end else begin
                win_off = int'(req.bin_angle) - HALF_TURN_UNITS;
                if (win_off < 0) win_off = -win_off;
                if (win_off <= SECTION_UNITS) loop_st.section_flag = 1'b1;
                diff = int'(req.bin_angle) - int'(loop_st.prior_angle);
                if (diff > HALF_TURN_UNITS) begin
                    // wrap through a full turn
                    if (loop_st.section_flag) begin
                        if (loop_st.current_count != '1) loop_st.current_count++;
                        if (loop_st.total_count != '1) loop_st.total_count++;
                    end
                    loop_st.prior_angle = req.bin_angle;
                end else if (diff < 0 && diff > -HALF_TURN_UNITS) begin
                    loop_st.prior_angle = req.bin_angle;
                end
                // everything else is jitter and leaves the state alone
            end
        end else if (req.trans_in) begin
            loop_st.angle_seeded  = 1'b0;
            loop_st.section_flag  = 1'b0;
            loop_st.current_count = '0;
        end
        res.current_revs = loop_st.current_count;
        res.total_revs   = loop_st.total_count;
        res.section_done = loop_st.section_flag;
        return res;
    endfunction

    // mostly no pause, sometimes a few cycles, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_flight_mode pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 78) return MODE_CW;
        if (r < 86) return MODE_IDLE;
        if (r < 93) return MODE_TIN;
        return MODE_BOTH;
    endfunction

    // angles steered by the stored angle so that progress, wraps and
    // jitter on both boundaries all come up often
    function automatic logic [ANGLE_BITS-1:0] pick_angle();
        logic [ANGLE_BITS-1:0] prior;
        prior = loop_st.prior_angle;
        case ($urandom_range(0, 9)) inside
            [0:2]: return prior - ANGLE_BITS'($urandom_range(1, 32767));
            [3:4]: begin
                if (prior < 16'd32767)
                    return ANGLE_BITS'($urandom_range(int'(prior) + 32769, 65535));
                return prior - ANGLE_BITS'($urandom_range(1, 32767));
            end
            5: return ANGLE_BITS'($urandom_range(HALF_TURN_UNITS - SECTION_UNITS - 4,
                                                 HALF_TURN_UNITS + SECTION_UNITS + 4));
            6: begin
                case ($urandom_range(0, 3))
                    0: return prior;
                    1: return prior ^ 16'h8000;
                    2: return prior + 16'd32767;
                    default: return prior - 16'd32767;
                endcase
            end
            7: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return ANGLE_BITS'($urandom);
        endcase
    endfunction

    // present one request, hold it until taken, then maybe pause
    task automatic offer(input t_plan_row row);
        lrc_pkg::t_lrc_out predicted;
        int                gap;
        i_in_valid <= 1'b1;
        i_in_data  <= row.req;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predicted = track_sample(row.req);
        counts_due.push_back(row.known ? row.want : predicted);
        if (hurry > 0) hurry--;
        gap = (steady || hurry > 0) ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result side: random stalls plus one long hold-off to back up the input
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0) begin
                if (hold_off_req && !hold_off_done) begin
                    hold_off_done = 1'b1;
                    hold_left     = HOLD_OFF_CYCLES;
                end else if (!steady) begin
                    hold_left = idle_len();
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // compare every taken result with the oldest prediction
    always @(posedge i_clk) begin
        lrc_pkg::t_lrc_out want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (counts_due.size() == 0) begin
                $display("%0t: result with nothing expected: cur %0d tot %0d sec %0b",
                         $time, o_out_data.current_revs, o_out_data.total_revs,
                         o_out_data.section_done);
                fail_count++;
            end else begin
                want = counts_due.pop_front();
                if (o_out_data.current_revs !== want.current_revs ||
                    o_out_data.total_revs !== want.total_revs ||
                    o_out_data.section_done !== want.section_done) begin
                    $display("%0t: expected cur %0d tot %0d sec %0b, got cur %0d tot %0d sec %0b",
                             $time, want.current_revs, want.total_revs, want.section_done,
                             o_out_data.current_revs, o_out_data.total_revs,
                             o_out_data.section_done);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_plan_row plan[$];

        // directed plan: boundaries of the difference, the section window
        // edges, both flags at once, hold and clear
        plan.push_back(known_row(16'd0,     MODE_IDLE, 0, 0, 1'b0)); // straight after reset
        plan.push_back(known_row(16'd32768, MODE_CW,   0, 0, 1'b0)); // seed only, no window test
        plan.push_back(known_row(16'd32768, MODE_CW,   0, 0, 1'b1)); // in window, zero diff
        plan.push_back(free_row(16'd1000,   MODE_CW));               // normal progress
        plan.push_back(free_row(16'd33769,  MODE_CW));               // wrap, counted
        plan.push_back(free_row(16'd1001,   MODE_CW));               // diff of minus half turn
        plan.push_back(free_row(16'd1,      MODE_CW));               // below minus half turn
        plan.push_back(free_row(16'd65535,  MODE_CW));               // positive but under half
        plan.push_back(free_row(16'd1002,   MODE_CW));               // just inside progress
        plan.push_back(free_row(16'd33770,  MODE_CW));               // diff of exactly half turn
        plan.push_back(free_row(16'd65535,  MODE_CW));               // wrap, counted
        plan.push_back(free_row(16'd0,      MODE_CW));               // largest negative diff
        plan.push_back(free_row(16'd32000,  MODE_BOTH));             // trans-in ignored
        plan.push_back(free_row(16'h5555,   MODE_IDLE));             // other mode holds
        plan.push_back(known_row(16'hAAAA,  MODE_TIN,  0, 2, 1'b0)); // clear keeps the total
        plan.push_back(free_row(16'd0,      MODE_CW));               // reseed
        plan.push_back(free_row(16'd40000,  MODE_CW));               // wrap before section done
        plan.push_back(free_row(16'd38229,  MODE_CW));               // upper window edge
        plan.push_back(known_row(16'hFFFF,  MODE_TIN,  0, 2, 1'b0));
        plan.push_back(free_row(16'd27307,  MODE_CW));
        plan.push_back(free_row(16'd27306,  MODE_CW));               // just below the window
        plan.push_back(free_row(16'd27307,  MODE_CW));               // lower window edge
        plan.push_back(free_row(16'd60076,  MODE_CW));               // wrap, counted
        plan.push_back(free_row(16'd38230,  MODE_CW));               // just above the window

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) offer(plan[k]);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 300) begin
                // result side holds off while requests keep coming
                hold_off_req = 1'b1;
                hurry        = 80;
            end
            steady = (i >= 700 && i < 800);
            offer(free_row(pick_angle(), pick_mode()));
        end
        steady = 1'b0;

        for (int i = 0; i < TAIL_ITEMS; i++) offer(free_row(pick_angle(), pick_mode()));
        i_in_valid <= 1'b0;

        while (counts_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
